### hdl/mpd_pkg.sv
// Shared types and constants of the MQTT packet deframer.
`timescale 1ns / 1ps

package mpd_pkg;

	localparam int MaxLengthBytes = 3;
	localparam int BodyW = 21;
	localparam int SumW = 29;
	localparam logic [BodyW-1:0] BodyMax = {BodyW{1'b1}};
	localparam logic [3:0] PublishKind = 4'd3;

	localparam logic [2:0] RoleHeader  = 3'd0;
	localparam logic [2:0] RoleLength  = 3'd1;
	localparam logic [2:0] RoleTlen    = 3'd2;
	localparam logic [2:0] RoleTopic   = 3'd3;
	localparam logic [2:0] RolePayload = 3'd4;
	localparam logic [2:0] RoleOther   = 3'd5;

	localparam logic CfgTopicLimit   = 1'b0;
	localparam logic CfgPayloadLimit = 1'b1;

	localparam logic [15:0] TopicLimitReset   = 16'd126;
	localparam logic [21:0] PayloadLimitReset = 22'd4096;

	typedef struct packed {
		logic [15:0] topic_limit;
		logic [21:0] payload_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [2:0] byte_role;
		logic [3:0] packet_kind;
		logic       retain_flag;
		logic       packet_end;
		logic       length_error;
		logic       topic_dropped;
		logic       topic_overrun;
		logic       payload_too_long;
	} result_t;

endpackage

### hdl/mpd_cfg.sv
// Configuration registers of the MQTT packet deframer.
`timescale 1ns / 1ps

module mpd_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_addr,
	input  logic [21:0]   cfg_wdata,
	output mpd_pkg::cfg_t cfg
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.topic_limit   <= mpd_pkg::TopicLimitReset;
			cfg.payload_limit <= mpd_pkg::PayloadLimitReset;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				mpd_pkg::CfgTopicLimit:   cfg.topic_limit   <= cfg_wdata[15:0];
				mpd_pkg::CfgPayloadLimit: cfg.payload_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule

### hdl/mpd_parser.sv
// Packet state and per-byte parse step of the MQTT packet deframer.
`timescale 1ns / 1ps

module mpd_parser #(
	parameter int MAX_LENGTH_BYTES = mpd_pkg::MaxLengthBytes
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       rx_byte,
	input  mpd_pkg::cfg_t    cfg,
	output mpd_pkg::result_t result
);

	localparam int LbW = $clog2(MAX_LENGTH_BYTES + 1);
	localparam int BodyW = mpd_pkg::BodyW;
	localparam int SumW = mpd_pkg::SumW;

	localparam logic [2:0] PhHeader  = 3'd0;
	localparam logic [2:0] PhLength  = 3'd1;
	localparam logic [2:0] PhTlenHi  = 3'd2;
	localparam logic [2:0] PhTlenLo  = 3'd3;
	localparam logic [2:0] PhTopic   = 3'd4;
	localparam logic [2:0] PhPayload = 3'd5;
	localparam logic [2:0] PhBody    = 3'd6;

	logic [2:0]       phase_q, phase_n;
	logic [3:0]       kind_q, kind_n;
	logic             retain_q, retain_n;
	logic [LbW-1:0]   seen_q, seen_n;
	logic [BodyW-1:0] body_q, body_n;
	logic [7:0]       tlen_hi_q, tlen_hi_n;
	logic [15:0]      topic_left_q, topic_left_n;
	logic             overrun_q, overrun_n;

	logic [4:0]       shamt;
	logic [SumW-1:0]  add, sum;
	logic [BodyW-1:0] body_dec, diff;
	logic [15:0]      tlen;

	assign shamt    = 5'(seen_q) * 5'd7;
	assign add      = SumW'(rx_byte[6:0]) << shamt;
	assign sum      = SumW'(body_q) + add;
	assign body_dec = body_q - BodyW'(1);
	assign tlen     = {tlen_hi_q, rx_byte};
	assign diff     = body_dec - BodyW'(tlen);

	always_comb begin
		phase_n      = phase_q;
		kind_n       = kind_q;
		retain_n     = retain_q;
		seen_n       = seen_q;
		body_n       = body_q;
		tlen_hi_n    = tlen_hi_q;
		topic_left_n = topic_left_q;
		overrun_n    = overrun_q;
		result       = '0;
		result.data_byte = rx_byte;
		result.byte_role = mpd_pkg::RoleOther;
		unique case (phase_q)
			PhLength: begin
				result.byte_role = mpd_pkg::RoleLength;
				if (seen_q >= LbW'(MAX_LENGTH_BYTES)) begin
					result.length_error = 1'b1;
					phase_n = PhHeader;
				end else begin
					body_n = (sum > SumW'(mpd_pkg::BodyMax)) ? mpd_pkg::BodyMax
					                                         : sum[BodyW-1:0];
					seen_n = seen_q + LbW'(1);
					if (!rx_byte[7]) begin
						if (body_n == '0) begin
							result.packet_end = 1'b1;
							result.topic_overrun = (kind_q == mpd_pkg::PublishKind);
							phase_n = PhHeader;
						end else begin
							phase_n = (kind_q == mpd_pkg::PublishKind) ? PhTlenHi : PhBody;
						end
					end
				end
			end
			PhTlenHi: begin
				result.byte_role = mpd_pkg::RoleTlen;
				tlen_hi_n = rx_byte;
				body_n = body_dec;
				if (body_dec == '0) begin
					result.packet_end = 1'b1;
					result.topic_overrun = 1'b1;
					phase_n = PhHeader;
				end else begin
					phase_n = PhTlenLo;
				end
			end
			PhTlenLo: begin
				result.byte_role = mpd_pkg::RoleTlen;
				body_n = body_dec;
				topic_left_n = tlen;
				result.topic_dropped = (tlen > cfg.topic_limit);
				if (BodyW'(tlen) > body_dec) begin
					overrun_n = 1'b1;
				end else begin
					result.payload_too_long = ({1'b0, diff} >= cfg.payload_limit);
				end
				if (body_dec == '0) begin
					result.packet_end = 1'b1;
					result.topic_overrun = overrun_n;
					phase_n = PhHeader;
				end else begin
					phase_n = (tlen != '0) ? PhTopic : PhPayload;
				end
			end
			PhTopic: begin
				result.byte_role = mpd_pkg::RoleTopic;
				body_n = body_dec;
				topic_left_n = topic_left_q - 16'd1;
				if (body_dec == '0) begin
					result.packet_end = 1'b1;
					result.topic_overrun = overrun_q;
					phase_n = PhHeader;
				end else if (topic_left_n == '0) begin
					phase_n = PhPayload;
				end
			end
			PhPayload, PhBody: begin
				result.byte_role = (phase_q == PhPayload) ? mpd_pkg::RolePayload
				                                          : mpd_pkg::RoleOther;
				body_n = body_dec;
				if (body_dec == '0) begin
					result.packet_end = 1'b1;
					phase_n = PhHeader;
				end
			end
			default: begin
				result.byte_role = mpd_pkg::RoleHeader;
				kind_n       = rx_byte[7:4];
				retain_n     = rx_byte[0];
				seen_n       = '0;
				body_n       = '0;
				tlen_hi_n    = '0;
				topic_left_n = '0;
				overrun_n    = 1'b0;
				phase_n      = PhLength;
			end
		endcase
		result.packet_kind = kind_n;
		result.retain_flag = retain_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PhHeader;
			kind_q       <= '0;
			retain_q     <= 1'b0;
			seen_q       <= '0;
			body_q       <= '0;
			tlen_hi_q    <= '0;
			topic_left_q <= '0;
			overrun_q    <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_n;
			kind_q       <= kind_n;
			retain_q     <= retain_n;
			seen_q       <= seen_n;
			body_q       <= body_n;
			tlen_hi_q    <= tlen_hi_n;
			topic_left_q <= topic_left_n;
			overrun_q    <= overrun_n;
		end
	end

endmodule

### hdl/mqtt_packet_deframer.sv
// Top level of the MQTT packet deframer.
`timescale 1ns / 1ps

// Splits a received byte stream into MQTT packets, one byte per beat. Every
// input beat gives exactly one output beat carrying the byte, its role within
// the packet, the packet kind and retain bit, and the error flags; tlast marks
// the last byte of a packet. Throughput is one beat per cycle while m_tready is
// held high, set by the combinational parse step that updates the packet state;
// each beat passes the input register, then the result register, to the output.
// A length field of more than MAX_LENGTH_BYTES bytes flags length_error on the
// extra byte and the next byte starts a new packet.
module mqtt_packet_deframer #(
	parameter int MAX_LENGTH_BYTES = mpd_pkg::MaxLengthBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] data_byte, [8] retain_flag, [9] length_error, [10] topic_dropped,
	// [11] topic_overrun, [12] payload_too_long, [15:13] zero
	output logic [15:0] m_tdata,
	output logic [6:0]  m_tuser,   // [2:0] byte_role, [6:3] packet_kind
	output logic        m_tlast,   // packet_end
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [21:0] cfg_wdata
);

	mpd_pkg::cfg_t    cfg;
	mpd_pkg::result_t result;
	mpd_pkg::result_t result_s2;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	mpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mpd_parser #(
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, result_s2.payload_too_long, result_s2.topic_overrun,
	                   result_s2.topic_dropped, result_s2.length_error,
	                   result_s2.retain_flag, result_s2.data_byte};
	assign m_tuser  = {result_s2.packet_kind, result_s2.byte_role};
	assign m_tlast  = result_s2.packet_end;

	a_lerr_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.length_error |-> !result_s2.packet_end
		&& result_s2.byte_role == mpd_pkg::RoleLength)
		else $error("length error beat carries packet end or wrong role");

	a_overrun_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.topic_overrun |-> result_s2.packet_end)
		else $error("topic overrun flagged away from packet end");

	a_flags_on_tlen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (result_s2.payload_too_long || result_s2.topic_dropped)
		|-> result_s2.byte_role == mpd_pkg::RoleTlen)
		else $error("topic flags raised outside topic length byte");

	a_header_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.byte_role == mpd_pkg::RoleHeader
		|-> !result.packet_end && !result.topic_overrun)
		else $error("header byte ends a packet");

endmodule
